[rtl/spq_pkg.sv]
// Shared types and request codes for the sorted priority queue.
// No dependencies; imported by the controller, datapath and top level.
package spq_pkg;

  typedef enum logic [1:0] {
    REQ_ENQUEUE = 2'd0,
    REQ_DEQUEUE = 2'd1,
    REQ_QUERY   = 2'd2
  } req_code_t;

  typedef enum logic {
    ST_READY = 1'b0,
    ST_HOLD  = 1'b1
  } ctrl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;  // capture a new result
    logic enq;   // insert the incoming entry
    logic deq;   // drop the front entry
    logic err;   // request flagged, storage unchanged
  } spq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
  } spq_status_t;

endpackage

[rtl/spq_ctrl.sv]
// Handshake and request decode for the sorted priority queue.
// Depends on spq_pkg; drives the command struct into spq_datapath.
module spq_ctrl
  import spq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  req_type,
  input  spq_status_t status,
  output spq_cmd_t    cmd
);

  ctrl_state_t state, state_next;
  logic        accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_READY;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_READY: begin
        if (accept) state_next = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_ready && !accept) state_next = ST_READY;
      end
      default: state_next = ST_READY;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    unique case (state)
      ST_READY: in_ready = 1'b1;
      ST_HOLD: begin
        // result taken this cycle frees the output register
        in_ready  = out_ready;
        out_valid = 1'b1;
      end
      default: ;
    endcase
    cmd.load = accept;
    unique case (req_type)
      REQ_ENQUEUE: begin
        cmd.enq = accept && !status.full;
        cmd.err = status.full;
      end
      REQ_DEQUEUE: begin
        cmd.deq = accept && !status.empty;
        cmd.err = status.empty;
      end
      default: ;  // query and unused code change nothing
    endcase
  end

endmodule

[rtl/spq_datapath.sv]
// Sorted slot storage with parallel compare, plus the result registers.
// Depends on spq_pkg; commanded by spq_ctrl.
module spq_datapath
  import spq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  spq_cmd_t                      cmd,
  output spq_status_t                   status,
  input  logic [15:0]                   item_tag,
  input  logic [15:0]                   item_priority,
  output logic [15:0]                   front_tag,
  output logic [15:0]                   front_priority,
  output logic [$clog2(CAPACITY+1)-1:0] entry_count,
  output logic                          is_empty,
  output logic                          req_error
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [15:0]      slot_priority [CAPACITY];
  logic [15:0]      slot_tag      [CAPACITY];
  logic [15:0]      slot_priority_next [CAPACITY];
  logic [15:0]      slot_tag_next      [CAPACITY];
  logic [CAPACITY-1:0] gt;
  logic [CAPACITY-1:0] take;
  logic [CNT_W-1:0] count, count_next;

  assign status.full  = (count == CNT_W'(CAPACITY));
  assign status.empty = (count == '0);

  // occupied slots whose priority is strictly larger move back one place
  for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
    assign gt[i]   = (CNT_W'(i) < count) && (slot_priority[i] > item_priority);
    assign take[i] = gt[i] || (CNT_W'(i) == count);

    always_comb begin
      slot_priority_next[i] = slot_priority[i];
      slot_tag_next[i]      = slot_tag[i];
      if (cmd.enq && take[i]) begin
        if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
          slot_priority_next[i] = slot_priority[(i > 0) ? i - 1 : 0];
          slot_tag_next[i]      = slot_tag[(i > 0) ? i - 1 : 0];
        end else begin
          slot_priority_next[i] = item_priority;
          slot_tag_next[i]      = item_tag;
        end
      end else if (cmd.deq && i < CAPACITY - 1) begin
        slot_priority_next[i] = slot_priority[(i < CAPACITY - 1) ? i + 1 : i];
        slot_tag_next[i]      = slot_tag[(i < CAPACITY - 1) ? i + 1 : i];
      end
    end

    always_ff @(posedge clk) begin
      slot_priority[i] <= slot_priority_next[i];
      slot_tag[i]      <= slot_tag_next[i];
    end
  end

  always_comb begin
    count_next = count;
    if (cmd.enq) begin
      count_next = count + CNT_W'(1);
    end else if (cmd.deq) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // result reflects the queue after the request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      front_tag      <= (count_next != '0) ? slot_tag_next[0] : 16'd0;
      front_priority <= (count_next != '0) ? slot_priority_next[0] : 16'd0;
      entry_count    <= count_next;
      is_empty       <= (count_next == '0);
      req_error      <= cmd.err;
    end
  end

endmodule

[rtl/sorted_priority_queue_top.sv]
// Sorted priority queue: request channel in, result channel out.
// Request: req_type (0 enqueue, 1 dequeue, 2 query), item_tag, item_priority,
// taken when in_valid and in_ready are high at a clock edge.
// Result: front_tag, front_priority, entry_count, is_empty, req_error,
// one per request, describing the queue after that request.
// The result is registered: it is valid the cycle after the request is taken.
// Throughput: one request per cycle while the receiver takes each result;
// slot compares and shifts all happen in parallel across the CAPACITY slots.
// A pending result sits in an output register; while the receiver stalls,
// in_ready stays low, and it rises in the cycle the result is taken, so a
// new request can enter as the old result leaves.
// Enqueue when full or dequeue when empty sets req_error and leaves the
// queue as is. Front fields read zero when the queue is empty.
// Reset (rst, synchronous) empties the queue and drops any pending result.
// Depends on spq_pkg, spq_ctrl and spq_datapath.
module sorted_priority_queue_top
  import spq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    req_type,
  input  logic [15:0]                   item_tag,
  input  logic [15:0]                   item_priority,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [15:0]                   front_tag,
  output logic [15:0]                   front_priority,
  output logic [$clog2(CAPACITY+1)-1:0] entry_count,
  output logic                          is_empty,
  output logic                          req_error
);

  spq_cmd_t    cmd;
  spq_status_t status;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .req_type  (req_type),
    .status    (status),
    .cmd       (cmd)
  );

  spq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .item_tag       (item_tag),
    .item_priority  (item_priority),
    .front_tag      (front_tag),
    .front_priority (front_priority),
    .entry_count    (entry_count),
    .is_empty       (is_empty),
    .req_error      (req_error)
  );

endmodule
